[design/clock_calendar_counter_top_defines.svh]
// Assertion macros shared by the clock and calendar checker.
// Each macro names the clock and the disable condition explicitly.
`ifndef CLOCK_CALENDAR_COUNTER_TOP_DEFINES_SVH
`define CLOCK_CALENDAR_COUNTER_TOP_DEFINES_SVH

// Same-cycle implication.
`define CCC_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication.
`define CCC_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

[design/ccc_pkg.sv]
// ----------------------------------------------------------------------------
// ccc_pkg
// Types, codes and helper functions of the real-time clock and calendar.
// ----------------------------------------------------------------------------
`default_nettype none

package ccc_pkg;

   localparam int CSR_ADDR_WIDTH = 3;
   localparam int CSR_DATA_WIDTH = 32;

   // Register indexes (word address).
   localparam logic REG_TICKS_PER_SECOND = 1'b0;

   localparam logic [15:0] TICKS_PER_SECOND_RESET = 16'd1000;

   // Commands.
   localparam logic [1:0] CMD_TICK = 2'd0;
   localparam logic [1:0] CMD_INC  = 2'd1;
   localparam logic [1:0] CMD_DEC  = 2'd2;

   // Adjustable units.
   localparam logic [2:0] UNIT_SEC   = 3'd0;
   localparam logic [2:0] UNIT_MIN   = 3'd1;
   localparam logic [2:0] UNIT_HOUR  = 3'd2;
   localparam logic [2:0] UNIT_DAY   = 3'd3;
   localparam logic [2:0] UNIT_MONTH = 3'd4;
   localparam logic [2:0] UNIT_YEAR  = 3'd5;

   // Time after reset: 23:59:50 on the 28th of February, year 21.
   localparam logic [5:0] SECOND_RESET = 6'd50;
   localparam logic [5:0] MINUTE_RESET = 6'd59;
   localparam logic [4:0] HOUR_RESET   = 5'd23;
   localparam logic [4:0] DAY_RESET    = 5'd28;
   localparam logic [3:0] MONTH_RESET  = 4'd2;
   localparam logic [6:0] YEAR_RESET   = 7'd21;

   typedef struct packed {
      logic [1:0] cmd;
      logic [2:0] adjust_unit;
   } ccc_req_type;

   typedef struct packed {
      logic [7:0] second_bcd;
      logic [7:0] minute_bcd;
      logic [7:0] hour_bcd;
      logic [7:0] day_bcd;
      logic [7:0] month_bcd;
      logic [7:0] year_bcd;
   } ccc_rsp_type;

   // Days in the month. Within 2000..2099 a year is a leap year exactly
   // when it is divisible by four, since 2000 itself is divisible by 400.
   function automatic logic [4:0] month_len(input logic [3:0] month,
                                            input logic [6:0] year);
      logic [4:0] len;
      unique case (month)
         4'd4, 4'd6, 4'd9, 4'd11: len = 5'd30;
         4'd2:                    len = (year[1:0] == 2'b00) ? 5'd29 : 5'd28;
         default:                 len = 5'd31;
      endcase
      return len;
   endfunction

   // Packed BCD of a value 0..99; the tens come from a reciprocal multiply.
   function automatic logic [7:0] to_bcd(input logic [6:0] v);
      logic [13:0] prod;
      logic [3:0]  tens;
      logic [6:0]  rem;
      prod = 14'(v) * 14'd103;
      tens = prod[13:10];
      rem  = v - 7'(7'({3'b000, tens}) * 7'd10);
      return {tens, rem[3:0]};
   endfunction

endpackage

`default_nettype wire

[design/clock_calendar_counter_top.sv]
// ----------------------------------------------------------------------------
// clock_calendar_counter_top
// Real-time clock and calendar for 2000..2099 with BCD outputs.
// ----------------------------------------------------------------------------
// Every accepted item (a base tick or an adjust command) produces exactly one
// result item carrying the updated time and date as packed BCD. An item is
// taken each cycle while req_ready is high, and its result leaves the output
// register; a second result register behind it lets one more item in while
// the first result is stalled, after which req_ready stays low until the
// stalled result is taken. The prescaler, the rolling carry chain and the BCD
// conversion are all done in the single pass between the time registers and
// the result register. After reset the clock reads 23:59:50 on 28 February,
// year 21, and ticks_per_second (word address 0) is 1000.
`default_nettype none

module clock_calendar_counter_top (
   input  wire                                   clock,
   input  wire                                   reset,
   input  wire                                   req_valid,
   output logic                                  req_ready,
   input  wire  ccc_pkg::ccc_req_type            req_data,
   output logic                                  rsp_valid,
   input  wire                                   rsp_ready,
   output ccc_pkg::ccc_rsp_type                  rsp_data,
   input  wire                                   csr_psel,
   input  wire                                   csr_penable,
   input  wire                                   csr_pwrite,
   input  wire  [ccc_pkg::CSR_ADDR_WIDTH-1:0]    csr_paddr,
   input  wire  [ccc_pkg::CSR_DATA_WIDTH-1:0]    csr_pwdata,
   output logic [ccc_pkg::CSR_DATA_WIDTH-1:0]    csr_prdata,
   output logic                                  csr_pready
);

   import ccc_pkg::*;

   logic [15:0] tps_ff;
   logic [15:0] tick_ff,   tick_in;
   logic [5:0]  second_ff, second_in;
   logic [5:0]  minute_ff, minute_in;
   logic [4:0]  hour_ff,   hour_in;
   logic [4:0]  day_ff,    day_in;
   logic [3:0]  month_ff,  month_in;
   logic [6:0]  year_ff,   year_in;

   logic        out_valid_ff;
   ccc_rsp_type out_data_ff;
   logic        skid_valid_ff;
   ccc_rsp_type skid_data_ff;

   logic        accept;
   logic        rsp_fire;
   logic        csr_write;
   logic        tick_roll;
   logic [16:0] tick_next;
   logic [5:0]  day_next;
   logic [4:0]  cur_len;
   ccc_rsp_type result;

   assign accept    = req_valid && req_ready;
   assign rsp_fire  = out_valid_ff && rsp_ready;
   assign csr_pready = 1'b1;
   assign csr_write = csr_psel && csr_penable && csr_pwrite && csr_pready;

   assign tick_next = {1'b0, tick_ff} + 17'd1;
   assign tick_roll = tick_next >= {1'b0, tps_ff};
   assign day_next  = {1'b0, day_ff} + 6'd1;
   assign cur_len   = month_len(month_ff, year_ff);

   // Next time and date for the item at the input.
   always_comb begin
      tick_in   = tick_ff;
      second_in = second_ff;
      minute_in = minute_ff;
      hour_in   = hour_ff;
      day_in    = day_ff;
      month_in  = month_ff;
      year_in   = year_ff;
      unique case (req_data.cmd)
         CMD_TICK: begin
            if (!tick_roll) begin
               tick_in = tick_next[15:0];
            end else begin
               tick_in = '0;
               if (second_ff < 6'd59) begin
                  second_in = second_ff + 6'd1;
               end else begin
                  second_in = '0;
                  if (minute_ff < 6'd59) begin
                     minute_in = minute_ff + 6'd1;
                  end else begin
                     minute_in = '0;
                     if (hour_ff < 5'd23) begin
                        hour_in = hour_ff + 5'd1;
                     end else begin
                        hour_in = '0;
                        if (day_next > {1'b0, cur_len}) begin
                           day_in = 5'd1;
                           if (month_ff >= 4'd12) begin
                              month_in = 4'd1;
                              year_in  = (year_ff >= 7'd99) ? 7'd0 : year_ff + 7'd1;
                           end else begin
                              month_in = month_ff + 4'd1;
                           end
                        end else begin
                           day_in = day_next[4:0];
                        end
                     end
                  end
               end
            end
         end
         CMD_INC: begin
            unique case (req_data.adjust_unit)
               UNIT_SEC:   second_in = (second_ff >= 6'd59) ? 6'd0 : second_ff + 6'd1;
               UNIT_MIN:   minute_in = (minute_ff >= 6'd59) ? 6'd0 : minute_ff + 6'd1;
               UNIT_HOUR:  hour_in   = (hour_ff >= 5'd23) ? 5'd0 : hour_ff + 5'd1;
               UNIT_DAY:   day_in    = (day_next > {1'b0, cur_len}) ? 5'd1 : day_next[4:0];
               UNIT_MONTH: month_in  = (month_ff >= 4'd12) ? 4'd1 : month_ff + 4'd1;
               UNIT_YEAR:  year_in   = (year_ff >= 7'd99) ? 7'd0 : year_ff + 7'd1;
               default: ;
            endcase
         end
         CMD_DEC: begin
            unique case (req_data.adjust_unit)
               UNIT_SEC:   second_in = (second_ff == 6'd0) ? 6'd59 : second_ff - 6'd1;
               UNIT_MIN:   minute_in = (minute_ff == 6'd0) ? 6'd59 : minute_ff - 6'd1;
               UNIT_HOUR:  hour_in   = (hour_ff == 5'd0) ? 5'd23 : hour_ff - 5'd1;
               UNIT_DAY:   day_in    = (day_ff <= 5'd1) ? cur_len : day_ff - 5'd1;
               UNIT_MONTH: month_in  = (month_ff <= 4'd1) ? 4'd12 : month_ff - 4'd1;
               UNIT_YEAR:  year_in   = (year_ff == 7'd0) ? 7'd99 : year_ff - 7'd1;
               default: ;
            endcase
         end
         default: ;
      endcase
   end

   always_comb begin
      result.second_bcd = to_bcd({1'b0, second_in});
      result.minute_bcd = to_bcd({1'b0, minute_in});
      result.hour_bcd   = to_bcd({2'b00, hour_in});
      result.day_bcd    = to_bcd({2'b00, day_in});
      result.month_bcd  = to_bcd({3'b000, month_in});
      result.year_bcd   = to_bcd(year_in);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tick_ff   <= '0;
         second_ff <= SECOND_RESET;
         minute_ff <= MINUTE_RESET;
         hour_ff   <= HOUR_RESET;
         day_ff    <= DAY_RESET;
         month_ff  <= MONTH_RESET;
         year_ff   <= YEAR_RESET;
      end else if (accept) begin
         tick_ff   <= tick_in;
         second_ff <= second_in;
         minute_ff <= minute_in;
         hour_ff   <= hour_in;
         day_ff    <= day_in;
         month_ff  <= month_in;
         year_ff   <= year_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tps_ff <= TICKS_PER_SECOND_RESET;
      end else if (csr_write && csr_paddr[2] == REG_TICKS_PER_SECOND) begin
         tps_ff <= csr_pwdata[15:0];
      end
   end

   always_comb begin
      if (csr_paddr[2] == REG_TICKS_PER_SECOND) begin
         csr_prdata = {{(CSR_DATA_WIDTH-16){1'b0}}, tps_ff};
      end else begin
         csr_prdata = '0;
      end
   end

   // Output register with one skid entry behind it; the skid entry always
   // holds the younger item.
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (skid_valid_ff) begin
         if (rsp_fire) begin
            out_valid_ff  <= 1'b1;
            skid_valid_ff <= 1'b0;
         end
      end else if (accept) begin
         if (!out_valid_ff || rsp_ready) begin
            out_valid_ff <= 1'b1;
         end else begin
            skid_valid_ff <= 1'b1;
         end
      end else if (rsp_fire) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (skid_valid_ff) begin
         if (rsp_fire) begin
            out_data_ff <= skid_data_ff;
         end
      end else if (accept) begin
         if (!out_valid_ff || rsp_ready) begin
            out_data_ff <= result;
         end else begin
            skid_data_ff <= result;
         end
      end
   end

   assign req_ready = !skid_valid_ff;
   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_data_ff;

endmodule

`default_nettype wire

[design/ccc_checker.sv]
// ----------------------------------------------------------------------------
// ccc_checker
// Port-level checks on the clock and calendar block, bound to its top level.
// ----------------------------------------------------------------------------
`default_nettype none
`include "clock_calendar_counter_top_defines.svh"

module ccc_checker (
   input wire                       clock,
   input wire                       reset,
   input wire                       req_ready,
   input wire                       rsp_valid,
   input wire                       rsp_ready,
   input wire ccc_pkg::ccc_rsp_type rsp_data
);

   import ccc_pkg::*;

   logic rsp_stalled;
   logic bcd_ok;

   assign rsp_stalled = rsp_valid && !rsp_ready;

   // Every reported value is valid BCD with a tens digit no higher than its unit allows.
   assign bcd_ok = rsp_data.second_bcd[7:4] <= 4'd5 && rsp_data.second_bcd[3:0] <= 4'd9 &&
                   rsp_data.minute_bcd[7:4] <= 4'd5 && rsp_data.minute_bcd[3:0] <= 4'd9 &&
                   rsp_data.hour_bcd[7:4] <= 4'd2 && rsp_data.hour_bcd[3:0] <= 4'd9 &&
                   rsp_data.day_bcd[7:4] <= 4'd3 && rsp_data.day_bcd[3:0] <= 4'd9 &&
                   rsp_data.month_bcd[7:4] <= 4'd1 && rsp_data.month_bcd[3:0] <= 4'd9 &&
                   rsp_data.year_bcd[7:4] <= 4'd9 && rsp_data.year_bcd[3:0] <= 4'd9;

   // A stalled result must stay offered and unchanged.
   `CCC_ASSERT_NXT(a_rsp_keep, clock, reset, rsp_stalled, rsp_valid, "stalled item withdrawn")
   `CCC_ASSERT_NXT(a_rsp_hold, clock, reset, rsp_stalled, $stable(rsp_data), "stalled item changed")

   // Reset empties both result registers.
   `CCC_ASSERT_NXT(a_reset_empty, clock, 1'b0, reset, !rsp_valid && req_ready, "buffer not empty")

   // The input only stalls when a result is waiting at the output.
   `CCC_ASSERT_IMP(a_stall_has_rsp, clock, reset, !req_ready, rsp_valid, "stall without result")

   `CCC_ASSERT_IMP(a_bcd_range, clock, reset, rsp_valid, bcd_ok, "value out of range")

endmodule

bind clock_calendar_counter_top ccc_checker u_ccc_checker (
   .clock     (clock),
   .reset     (reset),
   .req_ready (req_ready),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);

`default_nettype wire

[test/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top
// Self-checking testbench for the real-time clock and calendar.
// ----------------------------------------------------------------------------
// A scoreboard keeps its own copy of the prescaler, time and date and works
// out the BCD time that each accepted item should produce. The results are
// checked in order as they leave the block. The run starts with a short
// directed sequence. Random phases follow, each under a different prescaler
// setting. The random items come mostly as runs of one command, with some
// noise mixed in. Some runs steer the calendar to the end of a month or a
// year and then tick across the boundary. Both sides idle in random bursts,
// except in the last phase.

module tb_top;

   import ccc_pkg::*;

   class rtc_scoreboard;
      logic [15:0] ticks_per_second;
      logic [15:0] tick_count;
      logic [5:0]  second;
      logic [5:0]  minute;
      logic [4:0]  hour;
      logic [4:0]  day;
      logic [3:0]  month;
      logic [6:0]  year;
      ccc_rsp_type expected_times[$];
      int          errors;

      function new();
         ticks_per_second = TICKS_PER_SECOND_RESET;
         tick_count       = '0;
         second           = SECOND_RESET;
         minute           = MINUTE_RESET;
         hour             = HOUR_RESET;
         day              = DAY_RESET;
         month            = MONTH_RESET;
         year             = YEAR_RESET;
         errors           = 0;
      endfunction

      function void flag(string msg);
         errors++;
         if (errors <= 10) begin
            $display("%s", msg);
         end
      endfunction

      function int pending();
         return expected_times.size();
      endfunction

      function void set_ticks(logic [15:0] value);
         ticks_per_second = value;
      endfunction

      function bit is_leap();
         int y;
         y = int'(year) + 2000;
         return (y % 400 == 0) || ((y % 100 != 0) && (y % 4 == 0));
      endfunction

      function int days_in_month();
         case (month)
            4'd4, 4'd6, 4'd9, 4'd11: return 30;
            4'd2:                    return is_leap() ? 29 : 28;
            default:                 return 31;
         endcase
      endfunction

      function int value_of(logic [2:0] unit);
         case (unit)
            UNIT_SEC:   return int'(second);
            UNIT_MIN:   return int'(minute);
            UNIT_HOUR:  return int'(hour);
            UNIT_DAY:   return int'(day);
            UNIT_MONTH: return int'(month);
            UNIT_YEAR:  return int'(year);
            default:    return 0;
         endcase
      endfunction

      function int span_of(logic [2:0] unit);
         case (unit)
            UNIT_SEC, UNIT_MIN: return 60;
            UNIT_HOUR:          return 24;
            UNIT_DAY:           return days_in_month();
            UNIT_MONTH:         return 12;
            UNIT_YEAR:          return 100;
            default:            return 1;
         endcase
      endfunction

      function logic [7:0] packed_bcd(int v);
         return {4'((v / 10) % 10), 4'(v % 10)};
      endfunction

      // One second has passed: carry through the calendar. A day left beyond
      // the end of its month by an earlier adjust also wraps here.
      function void roll_second();
         int next_day;
         if (second < 6'd59) begin
            second = second + 6'd1;
            return;
         end
         second = '0;
         if (minute < 6'd59) begin
            minute = minute + 6'd1;
            return;
         end
         minute = '0;
         if (hour < 5'd23) begin
            hour = hour + 5'd1;
            return;
         end
         hour = '0;
         next_day = int'(day) + 1;
         if (next_day > days_in_month()) begin
            day   = 5'd1;
            month = month + 4'd1;
         end else begin
            day = 5'(next_day);
         end
         if (month > 4'd12) begin
            month = 4'd1;
            year  = (year >= 7'd99) ? 7'd0 : year + 7'd1;
         end
      endfunction

      // Adjusts wrap within their own unit and never carry into another.
      function void step_unit(logic [2:0] unit, bit up);
         int next_day;
         case (unit)
            UNIT_SEC: begin
               if (up) second = (second >= 6'd59) ? 6'd0 : second + 6'd1;
               else    second = (second == 6'd0) ? 6'd59 : second - 6'd1;
            end
            UNIT_MIN: begin
               if (up) minute = (minute >= 6'd59) ? 6'd0 : minute + 6'd1;
               else    minute = (minute == 6'd0) ? 6'd59 : minute - 6'd1;
            end
            UNIT_HOUR: begin
               if (up) hour = (hour >= 5'd23) ? 5'd0 : hour + 5'd1;
               else    hour = (hour == 5'd0) ? 5'd23 : hour - 5'd1;
            end
            UNIT_DAY: begin
               if (up) begin
                  next_day = int'(day) + 1;
                  day = (next_day > days_in_month()) ? 5'd1 : 5'(next_day);
               end else begin
                  day = (day <= 5'd1) ? 5'(days_in_month()) : day - 5'd1;
               end
            end
            UNIT_MONTH: begin
               if (up) month = (month >= 4'd12) ? 4'd1 : month + 4'd1;
               else    month = (month <= 4'd1) ? 4'd12 : month - 4'd1;
            end
            UNIT_YEAR: begin
               if (up) year = (year >= 7'd99) ? 7'd0 : year + 7'd1;
               else    year = (year == 7'd0) ? 7'd99 : year - 7'd1;
            end
            default: ;
         endcase
      endfunction

      function void take_item(ccc_req_type item);
         ccc_rsp_type want;
         int          next_tick;
         case (item.cmd)
            CMD_TICK: begin
               next_tick = int'(tick_count) + 1;
               if (next_tick >= int'(ticks_per_second)) begin
                  tick_count = '0;
                  roll_second();
               end else begin
                  tick_count = 16'(next_tick);
               end
            end
            CMD_INC: step_unit(item.adjust_unit, 1'b1);
            CMD_DEC: step_unit(item.adjust_unit, 1'b0);
            default: ;
         endcase
         want.second_bcd = packed_bcd(int'(second));
         want.minute_bcd = packed_bcd(int'(minute));
         want.hour_bcd   = packed_bcd(int'(hour));
         want.day_bcd    = packed_bcd(int'(day));
         want.month_bcd  = packed_bcd(int'(month));
         want.year_bcd   = packed_bcd(int'(year));
         expected_times.push_back(want);
      endfunction

      function void check_time(ccc_rsp_type got);
         ccc_rsp_type want;
         if (expected_times.size() == 0) begin
            flag($sformatf("result item with none expected: %h:%h:%h %h-%h-%h",
                           got.hour_bcd, got.minute_bcd, got.second_bcd,
                           got.day_bcd, got.month_bcd, got.year_bcd));
            return;
         end
         want = expected_times.pop_front();
         if (got.second_bcd !== want.second_bcd || got.minute_bcd !== want.minute_bcd ||
             got.hour_bcd !== want.hour_bcd || got.day_bcd !== want.day_bcd ||
             got.month_bcd !== want.month_bcd || got.year_bcd !== want.year_bcd) begin
            flag($sformatf("time mismatch: expected %h:%h:%h %h-%h-%h, got %h:%h:%h %h-%h-%h",
                           want.hour_bcd, want.minute_bcd, want.second_bcd,
                           want.day_bcd, want.month_bcd, want.year_bcd,
                           got.hour_bcd, got.minute_bcd, got.second_bcd,
                           got.day_bcd, got.month_bcd, got.year_bcd));
         end
      endfunction
   endclass

   localparam int WATCHDOG_LIMIT = 400;

   // Codes that the block treats as no operation.
   localparam logic [1:0] CMD_SPARE     = 2'd3;
   localparam logic [2:0] UNIT_SPARE_LO = 3'd6;
   localparam logic [2:0] UNIT_SPARE_HI = 3'd7;

   localparam logic [CSR_ADDR_WIDTH-1:0] TICKS_ADDR =
      CSR_ADDR_WIDTH'(4 * REG_TICKS_PER_SECOND);

   logic                      clock;
   logic                      reset;
   logic                      req_valid;
   logic                      req_ready;
   ccc_req_type               req_data;
   logic                      rsp_valid;
   logic                      rsp_ready;
   ccc_rsp_type               rsp_data;
   logic                      csr_psel;
   logic                      csr_penable;
   logic                      csr_pwrite;
   logic [CSR_ADDR_WIDTH-1:0] csr_paddr;
   logic [CSR_DATA_WIDTH-1:0] csr_pwdata;
   logic [CSR_DATA_WIDTH-1:0] csr_prdata;
   logic                      csr_pready;

   rtc_scoreboard sb;
   int            items_sent;
   bit            sender_idles;
   bit            receiver_stalls;

   clock_calendar_counter_top u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_data    (rsp_data),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   initial clock = 1'b0;
   always #10 clock = ~clock;

   // Each task starts and ends at a falling edge.
   task automatic send_item(input logic [1:0] cmd, input logic [2:0] unit);
      ccc_req_type item;
      item.cmd         = cmd;
      item.adjust_unit = unit;
      if (sender_idles && $urandom_range(0, 5) == 0) begin
         req_valid = 1'b0;
         repeat ($urandom_range(1, 13)) @(negedge clock);
      end
      req_data  = item;
      req_valid = 1'b1;
      do @(posedge clock); while (!req_ready);
      sb.take_item(item);
      items_sent++;
      @(negedge clock);
   endtask

   task automatic wait_idle;
      req_valid = 1'b0;
      while (sb.pending() != 0) @(negedge clock);
      repeat (3) @(negedge clock);
   endtask

   // Write the prescaler limit, then read it back in the next transfer.
   task automatic write_ticks(input logic [15:0] value);
      csr_paddr   = TICKS_ADDR;
      csr_pwdata  = {16'h0000, value};
      csr_pwrite  = 1'b1;
      csr_psel    = 1'b1;
      csr_penable = 1'b0;
      @(negedge clock);
      csr_penable = 1'b1;
      do @(posedge clock); while (!csr_pready);
      sb.set_ticks(value);
      @(negedge clock);
      csr_pwrite  = 1'b0;
      csr_penable = 1'b0;
      @(negedge clock);
      csr_penable = 1'b1;
      do @(posedge clock); while (!csr_pready);
      if (csr_prdata[15:0] !== value) begin
         sb.flag($sformatf("ticks_per_second read back %0d, written %0d",
                           csr_prdata[15:0], value));
      end
      @(negedge clock);
      csr_psel    = 1'b0;
      csr_penable = 1'b0;
   endtask

   // Step one unit by the shorter way round until it holds the goal. A day
   // beyond the end of its month is always stepped up, which wraps it.
   task automatic steer(input logic [2:0] unit, input int goal);
      int span;
      int ahead;
      while (sb.value_of(unit) != goal) begin
         span  = sb.span_of(unit);
         ahead = (((goal - sb.value_of(unit)) % span) + span) % span;
         send_item((sb.value_of(unit) > span || 2 * ahead <= span) ? CMD_INC : CMD_DEC,
                   unit);
      end
   endtask

   // Bring the clock to a few seconds before midnight on the 31st, with the
   // month often one that is shorter, and tick across the boundary.
   task automatic run_edge_case;
      int year_goal;
      year_goal = ($urandom_range(0, 2) == 0) ? 99 :
                  (sb.value_of(UNIT_YEAR) + $urandom_range(0, 12) + 94) % 100;
      steer(UNIT_YEAR, year_goal);
      steer(UNIT_MONTH, $urandom_range(0, 1) ? 12 : 1);
      steer(UNIT_DAY, 31);
      steer(UNIT_MONTH, $urandom_range(0, 1) ? 12 : $urandom_range(1, 12));
      steer(UNIT_HOUR, 23);
      steer(UNIT_MIN, 59);
      steer(UNIT_SEC, $urandom_range(50, 59));
      if ($urandom_range(0, 3) == 0) begin
         send_item(CMD_INC, UNIT_DAY);
      end
      repeat ($urandom_range(10, 40)) send_item(CMD_TICK, UNIT_SEC);
   endtask

   task automatic send_random(input int count, input int tick_pct, input int edge_pct);
      int         stop_at;
      int         len;
      int         pick;
      logic [1:0] cmd;
      logic [2:0] unit;
      stop_at = items_sent + count;
      while (items_sent < stop_at) begin
         pick = $urandom_range(0, 99);
         if (pick < edge_pct) begin
            run_edge_case();
         end else if (pick < 85) begin
            if ($urandom_range(0, 99) < tick_pct) begin
               cmd  = CMD_TICK;
               unit = 3'($urandom_range(0, 7));
               len  = $urandom_range(1, 40);
            end else begin
               cmd  = $urandom_range(0, 1) ? CMD_INC : CMD_DEC;
               unit = 3'($urandom_range(UNIT_SEC, UNIT_YEAR));
               len  = $urandom_range(1, 30);
            end
            repeat (len) send_item(cmd, unit);
         end else begin
            send_item(2'($urandom_range(0, 3)), 3'($urandom_range(0, 7)));
         end
      end
   endtask

   always begin : rsp_pacing
      @(negedge clock);
      if (receiver_stalls && $urandom_range(0, 5) == 0) begin
         rsp_ready = 1'b0;
         repeat ($urandom_range(1, 13)) @(negedge clock);
      end
      rsp_ready = 1'b1;
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         sb.check_time(rsp_data);
      end
   end

   initial begin : watchdog
      int quiet;
      quiet = 0;
      while (quiet < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) quiet = 0;
         else quiet++;
      end
      $display("DONE: errors detected");
      $finish;
   end

   initial begin
      sb              = new();
      items_sent      = 0;
      sender_idles    = 1'b1;
      receiver_stalls = 1'b1;
      reset           = 1'b1;
      req_valid       = 1'b0;
      req_data        = '0;
      rsp_ready       = 1'b0;
      csr_psel        = 1'b0;
      csr_penable     = 1'b0;
      csr_pwrite      = 1'b0;
      csr_paddr       = '0;
      csr_pwdata      = '0;
      repeat (12) @(negedge clock);
      reset = 1'b0;

      // Directed: no-op codes, every adjust both ways, then one second per
      // tick across the end of February in a common year.
      write_ticks(16'd1);
      send_item(CMD_SPARE, UNIT_YEAR);
      send_item(CMD_INC, UNIT_SPARE_LO);
      send_item(CMD_DEC, UNIT_SPARE_HI);
      for (int u = UNIT_SEC; u <= UNIT_YEAR; u++) begin
         send_item(CMD_INC, 3'(u));
         send_item(CMD_DEC, 3'(u));
      end
      repeat (11) send_item(CMD_TICK, UNIT_SEC);

      // A zero limit advances the seconds on every tick.
      wait_idle();
      write_ticks(16'd0);
      send_random(100, 40, 15);

      wait_idle();
      write_ticks(16'hFFFF);
      send_random(40, 50, 0);

      wait_idle();
      write_ticks(16'd3);
      send_random(100, 40, 15);

      // Build up a large prescaler count, then drop the limit below it.
      wait_idle();
      write_ticks(16'd200);
      send_random(80, 90, 0);

      wait_idle();
      write_ticks(16'd2);
      sender_idles    = 1'b0;
      receiver_stalls = 1'b0;
      send_random(110, 40, 15);

      wait_idle();
      repeat (4) @(negedge clock);
      if (sb.errors == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule
